[src/u8be_pkg.sv]
// Shared types and codes for the UART bit engine.
// Request and response structs, command and status codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u8be_pkg;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_START_TX = 2'd1,
    CMD_START_RX = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RX_ST_NONE      = 2'd0,
    RX_ST_ACCEPTED  = 2'd1,
    RX_ST_FALSE_ST  = 2'd2,
    RX_ST_BAD_STOP  = 2'd3
  } rx_status_e;

  localparam logic [8:0] PERIOD_RESET = 9'd96;
  localparam logic [8:0] PERIOD_MAX   = 9'd256;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] tx_byte;
    logic       rxd_level;
  } in_req_t;

  typedef struct packed {
    logic       txd_level;
    logic       tx_done;
    logic       rx_done;
    logic [7:0] rx_byte;
    logic       busy_res;
    logic [1:0] rx_status;
  } out_rsp_t;

endpackage

`default_nettype wire

[src/uart_8n1_bit_engine.sv]
// Top level of the half-duplex UART bit engine: request register, bit timer,
// frame state and response register. Depends on u8be_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One request (timer tick or start command) is taken every clock cycle while
// the response side keeps up. Each request gives exactly one response, held
// first in the request register and then in the response register. The
// request register takes a new request in the same cycle as its current one
// moves on. A waiting response that is not taken holds the request register,
// so one more request is taken and the input then stalls until the response
// side is ready again.
// The bit period (cfg_wdata_i, ticks per bit, 0 treated as 1 and anything
// above 256 as 256) resets to 96 and is picked up at the next timer reload.
module uart_8n1_bit_engine #(
  parameter int DATA_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [8:0]         cfg_wdata_i,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire u8be_pkg::in_req_t  in_req_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      u8be_pkg::out_rsp_t out_rsp_o
);
  import u8be_pkg::*;

  localparam logic [3:0] LastIdx  = 4'(DATA_BITS);
  localparam logic [3:0] StopIdx  = 4'(DATA_BITS + 1);
  localparam logic [7:0] DataMask = 8'((1 << DATA_BITS) - 1);

  // configuration
  logic [8:0] period_q;

  // request and response stages
  logic       req_valid_q;
  in_req_t    req_q;
  logic       rsp_valid_q;
  out_rsp_t   rsp_q;
  logic       advance;

  // frame state
  logic       tx_mode_q, tx_mode_d;
  logic       running_q, running_d;
  logic [7:0] tick_q, tick_d;
  logic [3:0] idx_q, idx_d;
  logic [7:0] tx_shift_q, tx_shift_d;
  logic [7:0] rx_shift_q, rx_shift_d;
  logic       line_q, line_d;
  logic       tx_fin_q, tx_fin_d;
  logic       rx_fin_q, rx_fin_d;
  rx_status_e status;

  logic [7:0] reload_full;
  logic [7:0] reload_half;
  logic [3:0] idx_inc;

  assign advance     = req_valid_q && (!rsp_valid_q || out_ready_i);
  assign in_ready_o  = !req_valid_q || advance;
  assign out_valid_o = rsp_valid_q;
  assign out_rsp_o   = rsp_q;
  assign idx_inc     = idx_q + 4'd1;

  // reload values: period minus one, and half period minus one
  always_comb begin
    if (period_q == 9'd0) begin
      reload_full = 8'd0;
      reload_half = 8'd0;
    end else if (period_q >= PERIOD_MAX) begin
      reload_full = 8'd255;
      reload_half = 8'd127;
    end else begin
      reload_full = period_q[7:0] - 8'd1;
      reload_half = (period_q[7:1] == 7'd0) ? 8'd0 : {1'b0, period_q[7:1]} - 8'd1;
    end
  end

  always_comb begin
    tx_mode_d  = tx_mode_q;
    running_d  = running_q;
    tick_d     = tick_q;
    idx_d      = idx_q;
    tx_shift_d = tx_shift_q;
    rx_shift_d = rx_shift_q;
    line_d     = line_q;
    tx_fin_d   = tx_fin_q;
    rx_fin_d   = rx_fin_q;
    status     = RX_ST_NONE;
    case (cmd_e'(req_q.command))
      CMD_TICK: begin
        if (running_q) begin
          if (tick_q != 8'd0) begin
            tick_d = tick_q - 8'd1;
          end else begin
            tick_d = reload_full;
            if (tx_mode_q) begin
              idx_d = idx_inc;
              if (idx_inc <= LastIdx) begin
                line_d     = tx_shift_q[0];
                tx_shift_d = {1'b0, tx_shift_q[7:1]};
              end else if (idx_inc == StopIdx) begin
                line_d = 1'b1;
              end else begin
                idx_d     = 4'd0;
                running_d = 1'b0;
                tx_fin_d  = 1'b1;
              end
            end else if (idx_q == 4'd0) begin
              // check the start bit half a period in
              if (!req_q.rxd_level) begin
                rx_shift_d = 8'd0;
                idx_d      = 4'd1;
              end else begin
                running_d = 1'b0;
                status    = RX_ST_FALSE_ST;
              end
            end else if (idx_q <= LastIdx) begin
              rx_shift_d = {1'b0, rx_shift_q[7:1]};
              rx_shift_d[DATA_BITS-1] = req_q.rxd_level;
              rx_shift_d = rx_shift_d & DataMask;
              idx_d      = idx_inc;
            end else begin
              idx_d     = 4'd0;
              running_d = 1'b0;
              if (req_q.rxd_level) begin
                rx_fin_d = 1'b1;
                status   = RX_ST_ACCEPTED;
              end else begin
                status = RX_ST_BAD_STOP;
              end
            end
          end
        end
      end
      CMD_START_TX: begin
        tx_shift_d = req_q.tx_byte & DataMask;
        tick_d     = reload_full;
        running_d  = 1'b1;
        line_d     = 1'b0;
        tx_fin_d   = 1'b0;
        tx_mode_d  = 1'b1;
        idx_d      = 4'd0;
      end
      CMD_START_RX: begin
        tick_d    = reload_half;
        running_d = 1'b1;
        rx_fin_d  = 1'b0;
        tx_mode_d = 1'b0;
        idx_d     = 4'd0;
      end
      default: begin
        // drop the request, report state as it stands
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_RESET;
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      tx_mode_q   <= 1'b0;
      running_q   <= 1'b0;
      tick_q      <= 8'd0;
      idx_q       <= 4'd0;
      tx_shift_q  <= 8'd0;
      rx_shift_q  <= 8'd0;
      line_q      <= 1'b1;
      tx_fin_q    <= 1'b0;
      rx_fin_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        req_valid_q <= in_valid_i;
      end
      if (advance) begin
        rsp_valid_q <= 1'b1;
        tx_mode_q   <= tx_mode_d;
        running_q   <= running_d;
        tick_q      <= tick_d;
        idx_q       <= idx_d;
        tx_shift_q  <= tx_shift_d;
        rx_shift_q  <= rx_shift_d;
        line_q      <= line_d;
        tx_fin_q    <= tx_fin_d;
        rx_fin_q    <= rx_fin_d;
      end else if (out_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
    if (advance) begin
      rsp_q.txd_level <= line_d;
      rsp_q.tx_done   <= tx_fin_d;
      rsp_q.rx_done   <= rx_fin_d;
      rsp_q.rx_byte   <= rx_shift_d;
      rsp_q.busy_res  <= running_d;
      rsp_q.rx_status <= status;
    end
  end

  // a stalled request stays in the request register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && !advance |=> req_valid_q)
    else $error("request lost while stalled");

  // bit index never passes the stop position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= StopIdx)
    else $error("bit index out of range");

  // any receive status ends the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (rsp_q.rx_status != RX_ST_NONE) |-> !rsp_q.busy_res)
    else $error("timer still running after receive status");

  // an accepted byte always raises the sticky flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (rsp_q.rx_status == RX_ST_ACCEPTED) |-> rsp_q.rx_done)
    else $error("byte accepted without rx_done");

  // a finished transmit leaves the line idle high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_mode_q && tx_fin_q |-> line_q)
    else $error("line low after transmit finished");

endmodule

`default_nettype wire

[tb/uart_8n1_bit_engine_tb.sv]
// Self-checking testbench for the UART bit engine: bursty tick and start requests, a
// stalling response side and a request-by-request frame predictor held in a scoreboard class.
// Depends on u8be_pkg and uart_8n1_bit_engine only.
`timescale 1ns / 1ps

module uart_8n1_bit_engine_tb;
  import u8be_pkg::*;

  localparam int         DATA_BITS = 8;
  localparam logic [7:0] DATA_MASK = 8'((1 << DATA_BITS) - 1);

  typedef enum int {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_PATTERN,
    READY_SPARSE
  } stall_mode_e;

  // Tracks the frame state of the engine and holds the responses still owed.
  class frame_tracker;
    logic [8:0] period;
    logic       tx_mode, running, line, tx_fin, rx_fin;
    logic [7:0] tick_cnt, tx_sh, rx_sh;
    logic [3:0] bit_idx;
    out_rsp_t   owed_rsp[$];
    int         mismatches, checked, requests, tx_frames_done;
    int         status_seen[4];

    function new();
      period   = PERIOD_RESET;
      tx_mode  = 1'b0;
      running  = 1'b0;
      line     = 1'b1;
      tx_fin   = 1'b0;
      rx_fin   = 1'b0;
      tick_cnt = '0;
      tx_sh    = '0;
      rx_sh    = '0;
      bit_idx  = '0;
      mismatches     = 0;
      checked        = 0;
      requests       = 0;
      tx_frames_done = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void take_request(in_req_t r);
      int         p, half;
      rx_status_e st;
      out_rsp_t   e;
      p  = (period == 0) ? 1 : ((period > PERIOD_MAX) ? int'(PERIOD_MAX) : int'(period));
      st = RX_ST_NONE;
      requests++;
      case (r.command)
        CMD_TICK: begin
          if (running && tick_cnt != 0) begin
            tick_cnt = tick_cnt - 1;
          end else if (running) begin
            tick_cnt = 8'(p - 1);
            if (tx_mode) begin
              bit_idx = bit_idx + 1;
              if (bit_idx <= DATA_BITS) begin
                line  = tx_sh[0];
                tx_sh = tx_sh >> 1;
              end else if (bit_idx == DATA_BITS + 1) begin
                line = 1'b1;
              end else begin
                bit_idx = '0;
                running = 1'b0;
                tx_fin  = 1'b1;
                tx_frames_done++;
              end
            end else if (bit_idx == 0) begin
              // start bit must still be low at mid-bit, else abort
              if (!r.rxd_level) begin
                rx_sh   = '0;
                bit_idx = 4'd1;
              end else begin
                running = 1'b0;
                st      = RX_ST_FALSE_ST;
              end
            end else if (bit_idx <= DATA_BITS) begin
              rx_sh   = ((rx_sh >> 1) | (8'(r.rxd_level) << (DATA_BITS - 1))) & DATA_MASK;
              bit_idx = bit_idx + 1;
            end else begin
              bit_idx = '0;
              running = 1'b0;
              if (r.rxd_level) begin
                rx_fin = 1'b1;
                st     = RX_ST_ACCEPTED;
              end else begin
                st = RX_ST_BAD_STOP;
              end
            end
          end
        end
        CMD_START_TX: begin
          tx_sh    = r.tx_byte & DATA_MASK;
          tick_cnt = 8'(p - 1);
          running  = 1'b1;
          line     = 1'b0;
          tx_fin   = 1'b0;
          tx_mode  = 1'b1;
          bit_idx  = '0;
        end
        CMD_START_RX: begin
          half = p / 2;
          if (half == 0) half = 1;
          tick_cnt = 8'(half - 1);
          running  = 1'b1;
          rx_fin   = 1'b0;
          tx_mode  = 1'b0;
          bit_idx  = '0;
        end
        default: ;
      endcase
      status_seen[int'(st)]++;
      e.txd_level = line;
      e.tx_done   = tx_fin;
      e.rx_done   = rx_fin;
      e.rx_byte   = rx_sh;
      e.busy_res  = running;
      e.rx_status = st;
      owed_rsp.push_back(e);
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      $display("MISMATCH at %0t ns, response %0d: %s", $time, checked, msg);
    endtask

    task match_response(out_rsp_t got);
      out_rsp_t e;
      if (owed_rsp.size() == 0) begin
        flag_mismatch($sformatf("response %h with none owed", got));
      end else begin
        e = owed_rsp.pop_front();
        checked++;
        if (got.txd_level !== e.txd_level)
          flag_mismatch($sformatf("txd_level want %0b got %0b", e.txd_level, got.txd_level));
        if (got.tx_done !== e.tx_done)
          flag_mismatch($sformatf("tx_done want %0b got %0b", e.tx_done, got.tx_done));
        if (got.rx_done !== e.rx_done)
          flag_mismatch($sformatf("rx_done want %0b got %0b", e.rx_done, got.rx_done));
        if (got.rx_byte !== e.rx_byte)
          flag_mismatch($sformatf("rx_byte want %h got %h", e.rx_byte, got.rx_byte));
        if (got.busy_res !== e.busy_res)
          flag_mismatch($sformatf("busy_res want %0b got %0b", e.busy_res, got.busy_res));
        if (got.rx_status !== e.rx_status)
          flag_mismatch($sformatf("rx_status want %0d got %0d", e.rx_status, got.rx_status));
      end
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [8:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  in_req_t    in_req_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_rsp_t   out_rsp_o;

  frame_tracker sb;
  int           burst_left;
  int           items_left;
  int           cur_period;

  uart_8n1_bit_engine #(
    .DATA_BITS(DATA_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("Timeout at %0t ns", $time);
    $display("uart_8n1_bit_engine_tb NOT OK");
    $finish;
  end

  // Response side: switch between stall patterns, each picked at random.
  initial begin
    stall_mode_e mode;
    int          left;
    out_ready_i <= 1'b0;
    mode = READY_ALWAYS;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        left = $urandom_range(20, 300);
      end
      left--;
      case (mode)
        READY_ALWAYS:  out_ready_i <= 1'b1;
        READY_MOSTLY:  out_ready_i <= ($urandom_range(0, 3) != 0);
        READY_PATTERN: out_ready_i <= ((left % 7) < 4);
        default:       out_ready_i <= ($urandom_range(0, 9) < 4);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.match_response(out_rsp_o);
  end

  // Send one request; bursts of random length with random gaps between them.
  task automatic send_req(cmd_e c, logic [7:0] b, logic rxd);
    in_req_t r;
    int      gap;
    r.command   = c;
    r.tx_byte   = b;
    r.rxd_level = rxd;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_request(r);
    burst_left--;
    items_left--;
  endtask

  // Hold off the sender until every owed response has come back.
  task automatic wait_all_responses();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.owed_rsp.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_period(logic [8:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.period  = v;
    cur_period = (v == 0) ? 1 : ((v > PERIOD_MAX) ? int'(PERIOD_MAX) : int'(v));
  endtask

  // One frame: transmit, clean receive, bad stop, false start or noise.
  // The receive line is laid out in whole bit periods from the start command.
  task automatic random_frame(int forced);
    int         kind, len, cut, t, bitno;
    logic [7:0] data;
    logic       lvl;
    kind = (forced >= 0) ? forced : $urandom_range(0, 99);
    data = 8'($urandom);
    len  = (DATA_BITS + 2) * cur_period + 2;
    cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : len;
    if (kind < 10) begin
      repeat ($urandom_range(1, 8))
        send_req(cmd_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
    end else if (kind < 50) begin
      send_req(CMD_START_TX, data, 1'($urandom));
      for (t = 0; t < cut && items_left > 0; t++)
        send_req(($urandom_range(0, 49) == 0) ? CMD_NONE : CMD_TICK, 8'($urandom),
                 1'($urandom));
    end else begin
      send_req(CMD_START_RX, 8'($urandom), 1'($urandom));
      for (t = 0; t < cut && items_left > 0; t++) begin
        bitno = t / cur_period;
        if (bitno == 0) lvl = (kind >= 93);
        else if (bitno <= DATA_BITS) lvl = data[bitno - 1];
        else if (bitno == DATA_BITS + 1) lvl = (kind < 85);
        else lvl = 1'b1;
        if ($urandom_range(0, 99) == 0) lvl = ~lvl;
        send_req(CMD_TICK, 8'($urandom), lvl);
      end
    end
    repeat ($urandom_range(0, 3))
      if (items_left > 0) send_req(CMD_TICK, 8'($urandom), 1'($urandom));
  endtask

  task automatic run_phase(logic [8:0] v, int budget, int forced);
    wait_all_responses();
    write_period(v);
    items_left = budget;
    // carry the previous frame across the period change for a few ticks
    repeat ($urandom_range(0, 4)) send_req(CMD_TICK, 8'($urandom), 1'($urandom));
    while (items_left > 0) random_frame(forced);
  endtask

  initial begin
    sb = new();
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_req_i    <= '0;
    burst_left = 0;
    items_left = 0;
    cur_period = int'(PERIOD_RESET);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reserved command, idle tick, then a false start at half the reset period
    send_req(CMD_NONE, 8'hFF, 1'b1);
    send_req(CMD_TICK, 8'h00, 1'b0);
    send_req(CMD_START_RX, 8'h00, 1'b1);
    repeat (48) send_req(CMD_TICK, 8'hFF, 1'b1);
    wait_all_responses();
    write_period(9'd1);

    // transmit restarted mid-frame, with a reserved command among the ticks
    send_req(CMD_START_TX, 8'hFF, 1'b0);
    send_req(CMD_TICK, 8'h00, 1'b1);
    send_req(CMD_START_TX, 8'h00, 1'b1);
    repeat (5) send_req(CMD_TICK, 8'hFF, 1'b0);
    send_req(CMD_NONE, 8'hA5, 1'b0);
    repeat (6) send_req(CMD_TICK, 8'h00, 1'b1);

    // receive of all ones ending on a low stop bit
    send_req(CMD_START_RX, 8'hFF, 1'b0);
    send_req(CMD_TICK, 8'h00, 1'b0);
    repeat (DATA_BITS) send_req(CMD_TICK, 8'h00, 1'b1);
    send_req(CMD_TICK, 8'h00, 1'b0);

    run_phase(9'd1,   250, -1);
    run_phase(9'd2,   200, -1);
    run_phase(9'd300, 140, 60);
    run_phase(9'd0,   150, -1);
    run_phase(9'd3,   150, -1);
    run_phase(9'd256, 270, 20);
    run_phase(9'd5,   150, -1);
    run_phase(9'd511, 135, 60);

    wait_all_responses();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d requests and %0d responses over periods 96 1 2 300 0 3 256 5 511",
             sb.requests, sb.checked);
    $display("Frames: %0d sent, %0d received, %0d false starts, %0d bad stop bits",
             sb.tx_frames_done, sb.status_seen[RX_ST_ACCEPTED],
             sb.status_seen[RX_ST_FALSE_ST], sb.status_seen[RX_ST_BAD_STOP]);
    if (sb.mismatches == 0) begin
      $display("uart_8n1_bit_engine_tb OK");
    end else begin
      $display("uart_8n1_bit_engine_tb NOT OK");
    end
    $finish;
  end

endmodule
